// ===== hdl/psd_pkg.sv =====
`default_nettype none
package psd_pkg;

	localparam int COORD_W = 32;
	localparam int T_FRAC  = 24;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int SQ_W    = 2 * DIFF_W;
	localparam int DOT_W   = SQ_W + 1;
	localparam int REM_W   = SQ_W + 1;
	localparam int T_W     = T_FRAC + 1;
	localparam int OFFP_W  = T_W + DIFF_W;
	localparam int ROOT_W  = DIFF_W;
	localparam int SREM_W  = ROOT_W + 3;

	// Stage counts of each unit.
	localparam int FRONT_STAGES = 3;
	localparam int NEAR_STAGES  = 5;
	localparam int LATENCY      = FRONT_STAGES + T_FRAC + NEAR_STAGES + ROOT_W;

	typedef struct packed {
		logic signed [COORD_W-1:0] query_x;
		logic signed [COORD_W-1:0] query_y;
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
	} item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] near_x;
		logic signed [COORD_W-1:0] near_y;
		logic        [COORD_W:0]   gap;
	} result_t;

	// Geometry that travels beside the arithmetic.
	typedef struct packed {
		logic signed [COORD_W-1:0] qx;
		logic signed [COORD_W-1:0] qy;
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		logic signed [DIFF_W-1:0]  dx;
		logic signed [DIFF_W-1:0]  dy;
	} ctx_t;

	// Clamp decisions taken before the division.
	typedef struct packed {
		logic t_zero;
		logic t_one;
	} clamp_t;

endpackage
`default_nettype wire

// ===== hdl/point_segment_closest_distance.sv =====
`default_nettype none
// Closest point on a segment and the distance to it, in signed Q16.16 fixed point.
// A transaction is accepted at every rising edge where start is high; busy is
// always low, so one query may enter in every cycle. The matching result appears
// at the end of the pipeline, for one cycle, marked by done, and results
// leave in the order the queries came in. The receiver cannot stall the block and
// must take each result in the cycle that done is high. The latency is set by the
// 24-stage projection divider (one bit of t per stage) and the 33-stage square
// root (one result bit per stage), plus three front stages for the differences,
// products and sums, and five stages that form the closest point and the squared
// distance.
module point_segment_closest_distance (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire psd_pkg::item_t   item,
	output logic                  done,
	output psd_pkg::result_t      result
);
	import psd_pkg::*;

	logic            front_v, div_v, near_v;
	ctx_t            front_ctx, div_ctx;
	logic [SQ_W-1:0] front_len2, front_rem, near_d2;
	clamp_t          front_clamp;
	logic [T_W-1:0]  div_t;
	logic signed [COORD_W-1:0] near_x, near_y;

	// The pipeline never holds anything back.
	assign busy = 1'b0;

	// Differences, the four products, then len2, dot and the clamp decision.
	psd_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(start && !busy), .item(item),
		.out_valid(front_v), .ctx(front_ctx), .len2(front_len2),
		.rem(front_rem), .clamp(front_clamp)
	);

	// Projection parameter t = dot / len2, clamped to [0, 1] and truncated to 24 fraction bits.
	psd_div u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(front_v), .ctx_in(front_ctx),
		.len2(front_len2), .rem(front_rem), .clamp_in(front_clamp),
		.out_valid(div_v), .ctx_out(div_ctx), .t(div_t)
	);

	// Closest point S + t*(E-S), rounded, and its squared distance to Q.
	psd_near u_near (
		.clk(clk), .arst_n(arst_n), .in_valid(div_v), .ctx(div_ctx), .t(div_t),
		.out_valid(near_v), .near_x(near_x), .near_y(near_y), .dist2(near_d2)
	);

	// Floor square root of the squared distance.
	psd_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .in_valid(near_v), .radicand(near_d2),
		.near_x_in(near_x), .near_y_in(near_y),
		.out_valid(done), .result(result)
	);
endmodule
`default_nettype wire

// ===== hdl/psd_front.sv =====
`default_nettype none
module psd_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire psd_pkg::item_t              item,
	output logic                             out_valid,
	output psd_pkg::ctx_t                    ctx,
	output logic [psd_pkg::SQ_W-1:0]         len2,
	output logic [psd_pkg::SQ_W-1:0]         rem,
	output psd_pkg::clamp_t                  clamp
);
	import psd_pkg::*;

	logic                      v_s1, v_s2, v_s3;
	ctx_t                      ctx_s1, ctx_s2, ctx_s3;
	logic signed [DIFF_W-1:0]  px_s1, py_s1;
	logic signed [SQ_W-1:0]    dxx_s2, dyy_s2, pxd_s2, pyd_s2;
	logic        [SQ_W-1:0]    len2_s3, rem_s3;
	clamp_t                    clamp_s3;
	logic        [SQ_W-1:0]    len2_c;
	logic signed [DOT_W-1:0]   dot_c;
	logic                      zero_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		len2_c = SQ_W'(dxx_s2) + SQ_W'(dyy_s2);
		dot_c  = DOT_W'(pxd_s2) + DOT_W'(pyd_s2);
		zero_c = (len2_c == '0) || dot_c[DOT_W-1] || (dot_c == '0);
	end

	always_ff @(posedge clk) begin
		ctx_s1.qx <= item.query_x;
		ctx_s1.qy <= item.query_y;
		ctx_s1.sx <= item.start_x;
		ctx_s1.sy <= item.start_y;
		ctx_s1.dx <= $signed({item.end_x[COORD_W-1], item.end_x})
			- $signed({item.start_x[COORD_W-1], item.start_x});
		ctx_s1.dy <= $signed({item.end_y[COORD_W-1], item.end_y})
			- $signed({item.start_y[COORD_W-1], item.start_y});
		px_s1 <= $signed({item.query_x[COORD_W-1], item.query_x})
			- $signed({item.start_x[COORD_W-1], item.start_x});
		py_s1 <= $signed({item.query_y[COORD_W-1], item.query_y})
			- $signed({item.start_y[COORD_W-1], item.start_y});

		ctx_s2 <= ctx_s1;
		dxx_s2 <= ctx_s1.dx * ctx_s1.dx;
		dyy_s2 <= ctx_s1.dy * ctx_s1.dy;
		pxd_s2 <= px_s1 * ctx_s1.dx;
		pyd_s2 <= py_s1 * ctx_s1.dy;

		ctx_s3 <= ctx_s2;
		len2_s3 <= len2_c;
		rem_s3 <= dot_c[SQ_W-1:0];
		clamp_s3.t_zero <= zero_c;
		clamp_s3.t_one  <= !zero_c && (dot_c[SQ_W-1:0] >= len2_c);
	end

	assign out_valid = v_s3;
	assign ctx       = ctx_s3;
	assign len2      = len2_s3;
	assign rem       = rem_s3;
	assign clamp     = clamp_s3;
endmodule
`default_nettype wire

// ===== hdl/psd_div.sv =====
`default_nettype none
module psd_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire psd_pkg::ctx_t               ctx_in,
	input  wire logic [psd_pkg::SQ_W-1:0]    len2,
	input  wire logic [psd_pkg::SQ_W-1:0]    rem,
	input  wire psd_pkg::clamp_t             clamp_in,
	output logic                             out_valid,
	output psd_pkg::ctx_t                    ctx_out,
	output logic [psd_pkg::T_W-1:0]          t
);
	import psd_pkg::*;

	// One quotient bit per stage, restoring division.
	logic                v_pipe     [0:T_FRAC];
	ctx_t                ctx_pipe   [0:T_FRAC];
	logic [SQ_W-1:0]     len2_pipe  [0:T_FRAC];
	logic [SQ_W-1:0]     rem_pipe   [0:T_FRAC];
	clamp_t              clamp_pipe [0:T_FRAC];
	logic [T_FRAC-1:0]   q_pipe     [0:T_FRAC];

	assign v_pipe[0]     = in_valid;
	assign ctx_pipe[0]   = ctx_in;
	assign len2_pipe[0]  = len2;
	assign rem_pipe[0]   = rem;
	assign clamp_pipe[0] = clamp_in;
	assign q_pipe[0]     = '0;

	for (genvar i = 0; i < T_FRAC; i++) begin : g_step
		logic [REM_W-1:0] shifted;
		logic             fits;
		assign shifted = {rem_pipe[i], 1'b0};
		assign fits    = shifted >= REM_W'(len2_pipe[i]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_pipe[i+1] <= 1'b0;
			end else begin
				v_pipe[i+1] <= v_pipe[i];
			end
		end

		always_ff @(posedge clk) begin
			ctx_pipe[i+1]   <= ctx_pipe[i];
			len2_pipe[i+1]  <= len2_pipe[i];
			clamp_pipe[i+1] <= clamp_pipe[i];
			q_pipe[i+1]     <= {q_pipe[i][T_FRAC-2:0], fits};
			rem_pipe[i+1]   <= fits ? SQ_W'(shifted - REM_W'(len2_pipe[i]))
				: shifted[SQ_W-1:0];
		end
	end

	assign out_valid = v_pipe[T_FRAC];
	assign ctx_out   = ctx_pipe[T_FRAC];

	always_comb begin
		if (clamp_pipe[T_FRAC].t_zero) begin
			t = '0;
		end else if (clamp_pipe[T_FRAC].t_one) begin
			t = T_W'(1) << T_FRAC;
		end else begin
			t = {1'b0, q_pipe[T_FRAC]};
		end
	end
endmodule
`default_nettype wire

// ===== hdl/psd_near.sv =====
`default_nettype none
module psd_near (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire psd_pkg::ctx_t                 ctx,
	input  wire logic [psd_pkg::T_W-1:0]       t,
	output logic                               out_valid,
	output logic signed [psd_pkg::COORD_W-1:0] near_x,
	output logic signed [psd_pkg::COORD_W-1:0] near_y,
	output logic [psd_pkg::SQ_W-1:0]           dist2
);
	import psd_pkg::*;

	localparam int SP_W = OFFP_W + 2;

	logic                       v_s1, v_s2, v_s3, v_s4, v_s5;
	ctx_t                       ctx_s1, ctx_s2;
	logic [OFFP_W-1:0]          prx_s1, pry_s1;
	logic                       negx_s1, negy_s1;
	logic signed [COORD_W-1:0]  nx_s2, ny_s2, nx_s3, ny_s3, nx_s4, ny_s4, nx_s5, ny_s5;
	logic signed [DIFF_W-1:0]   gx_s3, gy_s3;
	logic [SQ_W-1:0]            gxx_s4, gyy_s4, d2_s5;
	logic [DIFF_W-1:0]          magx, magy;
	logic signed [SP_W-1:0]     spx, spy;

	always_comb begin
		magx = ctx.dx[DIFF_W-1] ? DIFF_W'(-ctx.dx) : DIFF_W'(ctx.dx);
		magy = ctx.dy[DIFF_W-1] ? DIFF_W'(-ctx.dy) : DIFF_W'(ctx.dy);
		// Round half up, then drop the fraction bits of t.
		spx = (negx_s1 ? -$signed({2'b00, prx_s1}) : $signed({2'b00, prx_s1}))
			+ $signed(SP_W'(1) << (T_FRAC - 1));
		spy = (negy_s1 ? -$signed({2'b00, pry_s1}) : $signed({2'b00, pry_s1}))
			+ $signed(SP_W'(1) << (T_FRAC - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s1  <= ctx;
		prx_s1  <= OFFP_W'(t) * OFFP_W'(magx);
		pry_s1  <= OFFP_W'(t) * OFFP_W'(magy);
		negx_s1 <= ctx.dx[DIFF_W-1];
		negy_s1 <= ctx.dy[DIFF_W-1];

		ctx_s2 <= ctx_s1;
		nx_s2  <= ctx_s1.sx + COORD_W'(spx >>> T_FRAC);
		ny_s2  <= ctx_s1.sy + COORD_W'(spy >>> T_FRAC);

		nx_s3  <= nx_s2;
		ny_s3  <= ny_s2;
		gx_s3  <= $signed({ctx_s2.qx[COORD_W-1], ctx_s2.qx})
			- $signed({nx_s2[COORD_W-1], nx_s2});
		gy_s3  <= $signed({ctx_s2.qy[COORD_W-1], ctx_s2.qy})
			- $signed({ny_s2[COORD_W-1], ny_s2});

		nx_s4  <= nx_s3;
		ny_s4  <= ny_s3;
		gxx_s4 <= SQ_W'(SQ_W'(gx_s3) * SQ_W'(gx_s3));
		gyy_s4 <= SQ_W'(SQ_W'(gy_s3) * SQ_W'(gy_s3));

		nx_s5 <= nx_s4;
		ny_s5 <= ny_s4;
		d2_s5 <= gxx_s4 + gyy_s4;
	end

	assign out_valid = v_s5;
	assign near_x    = nx_s5;
	assign near_y    = ny_s5;
	assign dist2     = d2_s5;
endmodule
`default_nettype wire

// ===== hdl/psd_sqrt.sv =====
`default_nettype none
module psd_sqrt (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic [psd_pkg::SQ_W-1:0]      radicand,
	input  wire logic signed [psd_pkg::COORD_W-1:0] near_x_in,
	input  wire logic signed [psd_pkg::COORD_W-1:0] near_y_in,
	output logic                               out_valid,
	output psd_pkg::result_t                   result
);
	import psd_pkg::*;

	// Digit-by-digit square root, two radicand bits per stage.
	logic                       v_pipe    [0:ROOT_W];
	logic [SQ_W-1:0]            rad_pipe  [0:ROOT_W];
	logic [SREM_W-1:0]          rem_pipe  [0:ROOT_W];
	logic [ROOT_W-1:0]          root_pipe [0:ROOT_W];
	logic signed [COORD_W-1:0]  nx_pipe   [0:ROOT_W];
	logic signed [COORD_W-1:0]  ny_pipe   [0:ROOT_W];

	assign v_pipe[0]    = in_valid;
	assign rad_pipe[0]  = radicand;
	assign rem_pipe[0]  = '0;
	assign root_pipe[0] = '0;
	assign nx_pipe[0]   = near_x_in;
	assign ny_pipe[0]   = near_y_in;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_digit
		logic [SREM_W-1:0] shifted;
		logic [SREM_W-1:0] trial;
		logic              fits;
		assign shifted = {rem_pipe[i][SREM_W-3:0], rad_pipe[i][SQ_W-1-2*i -: 2]};
		assign trial   = SREM_W'({root_pipe[i], 2'b01});
		assign fits    = shifted >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_pipe[i+1] <= 1'b0;
			end else begin
				v_pipe[i+1] <= v_pipe[i];
			end
		end

		always_ff @(posedge clk) begin
			rad_pipe[i+1]  <= rad_pipe[i];
			nx_pipe[i+1]   <= nx_pipe[i];
			ny_pipe[i+1]   <= ny_pipe[i];
			rem_pipe[i+1]  <= fits ? shifted - trial : shifted;
			root_pipe[i+1] <= {root_pipe[i][ROOT_W-2:0], fits};
		end
	end

	assign out_valid     = v_pipe[ROOT_W];
	assign result.near_x = nx_pipe[ROOT_W];
	assign result.near_y = ny_pipe[ROOT_W];
	assign result.gap    = root_pipe[ROOT_W];
endmodule
`default_nettype wire

// ===== hdl/psd_checker.sv =====
`default_nettype none
module psd_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire logic             done
);
	import psd_pkg::*;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised by a pipeline that cannot stall");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted transaction produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching transaction");
endmodule

bind point_segment_closest_distance psd_checker u_psd_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done)
);
`default_nettype wire
